// File: hw/rtl/tee_pkg.sv
// Shared types and constants of the token expression evaluator.
package tee_pkg;

  localparam int unsigned NestDepth  = 8;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned LevelWidth = $clog2(NestDepth + 1);
  localparam int unsigned IdxWidth   = (NestDepth > 1) ? $clog2(NestDepth) : 1;
  localparam int unsigned CntWidth   = $clog2(ValueWidth + 1);

  typedef enum logic [1:0] {
    CmdNumber = 2'd0,
    CmdOper   = 2'd1,
    CmdOpen   = 2'd2,
    CmdClose  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    OpAdd     = 4'd0,
    OpSub     = 4'd1,
    OpMul     = 4'd2,
    OpDiv     = 4'd3,
    OpMod     = 4'd4,
    OpAnd     = 4'd5,
    OpOr      = 4'd6,
    OpShl     = 4'd7,
    OpShr     = 4'd8,
    OpUnknown = 4'd9
  } op_e;

  typedef enum logic [2:0] {
    StIdle,
    StApply,
    StDivide,
    StPop,
    StFlush,
    StOut
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic token_load;  // capture the token and run its bookkeeping
    logic apply_start; // start applying pending op (operand in opnd)
    logic div_step;    // one restoring-division step
    logic apply_done;  // write apply result into accumulator
    logic pop;         // restore level from stack, operand = inner acc
    logic clear;       // return to reset state
  } tee_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_apply;  // token_load or pop produced an operand to take
    logic need_pop;    // token was a valid close
    logic is_div;      // operation needs the divider
    logic div_last;    // last divide step
    logic level_open;  // nest level nonzero
  } tee_sts_t;

endpackage

// File: hw/rtl/tee_datapath.sv
// Datapath: accumulator, level stack, operator unit and serial divider.
module tee_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tee_pkg::tee_cmd_t                  cmd_i,
  output tee_pkg::tee_sts_t                  sts_o,
  input  logic [1:0]                         tok_cmd_i,
  input  logic [tee_pkg::ValueWidth-1:0]     tok_value_i,
  input  logic [3:0]                         tok_op_i,
  output logic [tee_pkg::ValueWidth-1:0]     result_o,
  output logic                               overflow_o
);
  import tee_pkg::*;

  localparam int unsigned W = ValueWidth;

  logic [W-1:0]          acc_q, acc_d;
  logic [3:0]            pend_q, pend_d;
  logic                  want_q, want_d;
  logic                  empty_q, empty_d;
  logic [LevelWidth-1:0] lvl_q, lvl_d;
  logic                  ovf_q, ovf_d;
  logic [W-1:0]          opnd_q, opnd_d;
  logic                  need_apply_q, need_apply_d;
  logic                  need_pop_q, need_pop_d;

  // Level stack
  logic [W-1:0] stk_acc_q   [NestDepth];
  logic [3:0]   stk_op_q    [NestDepth];
  logic         stk_empty_q [NestDepth];
  logic                push;
  logic [IdxWidth-1:0] push_idx, pop_idx;

  // Divider
  logic [W-1:0]        quo_q, rem_q, dvd_q;
  logic [CntWidth-1:0] cnt_q;
  logic [W:0]          trial;
  logic [W:0]          rem_sh;
  logic [W-1:0]        alu;
  logic [2*W-1:0]      prod;

  assign push_idx = lvl_q[IdxWidth-1:0];
  assign pop_idx  = IdxWidth'(lvl_q - LevelWidth'(1));
  assign rem_sh   = {rem_q, dvd_q[W-1]};
  assign trial    = rem_sh - {1'b0, opnd_q};
  assign prod     = acc_q * opnd_q;

  // Pick the operator result; divide and modulo take the divider's quotient and remainder.
  always_comb begin
    case (pend_q)
      OpAdd: alu = acc_q + opnd_q;
      OpSub: alu = acc_q - opnd_q;
      OpMul: alu = prod[W-1:0];
      OpDiv: alu = (opnd_q == '0) ? '1 : quo_q;
      OpMod: alu = (opnd_q == '0) ? acc_q : rem_q;
      OpAnd: alu = acc_q & opnd_q;
      OpOr:  alu = acc_q | opnd_q;
      OpShl: alu = (opnd_q >= W) ? '0 : acc_q << opnd_q[CntWidth-1:0];
      OpShr: alu = (opnd_q >= W) ? '0 : acc_q >> opnd_q[CntWidth-1:0];
      default: alu = acc_q;
    endcase
  end

  assign sts_o.need_apply = need_apply_q;
  assign sts_o.need_pop   = need_pop_q;
  assign sts_o.is_div     = ((pend_q == OpDiv) || (pend_q == OpMod)) && !empty_q
                            && (opnd_q != '0);
  assign sts_o.div_last   = (cnt_q == CntWidth'(W - 1));
  assign sts_o.level_open = (lvl_q != '0);
  assign result_o   = acc_q;
  assign overflow_o = ovf_q;

  // Next state of the level registers.
  always_comb begin
    acc_d = acc_q; pend_d = pend_q; want_d = want_q; empty_d = empty_q;
    lvl_d = lvl_q; ovf_d = ovf_q; opnd_d = opnd_q;
    need_apply_d = 1'b0; need_pop_d = 1'b0; push = 1'b0;
    if (cmd_i.clear) begin
      acc_d = '0; pend_d = OpUnknown; want_d = 1'b1; empty_d = 1'b1;
      lvl_d = '0; ovf_d = 1'b0;
    end else if (cmd_i.token_load) begin
      unique case (cmd_e'(tok_cmd_i))
        CmdNumber: begin
          if (want_q) begin
            opnd_d = tok_value_i; need_apply_d = 1'b1;
          end else begin
            pend_d = OpUnknown; want_d = 1'b1;
          end
        end
        CmdOper: begin
          if (!want_q) begin
            pend_d = tok_op_i; want_d = 1'b1;
          end
        end
        CmdOpen: begin
          if (want_q) begin
            if (lvl_q < LevelWidth'(NestDepth)) begin
              push = 1'b1; lvl_d = lvl_q + LevelWidth'(1);
              acc_d = '0; pend_d = OpUnknown; empty_d = 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            pend_d = OpUnknown; want_d = 1'b1;
          end
        end
        default: need_pop_d = (lvl_q != '0);
      endcase
    end else if (cmd_i.pop) begin
      opnd_d = acc_q; lvl_d = lvl_q - LevelWidth'(1);
      acc_d = stk_acc_q[pop_idx]; pend_d = stk_op_q[pop_idx];
      empty_d = stk_empty_q[pop_idx]; need_apply_d = 1'b1;
    end else if (cmd_i.apply_done) begin
      acc_d = empty_q ? opnd_q : alu; empty_d = 1'b0; want_d = 1'b0;
    end
  end

  // Hold control and level registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= OpUnknown; want_q <= 1'b1; empty_q <= 1'b1;
      lvl_q <= '0; ovf_q <= 1'b0; need_apply_q <= 1'b0; need_pop_q <= 1'b0;
    end else begin
      pend_q <= pend_d; want_q <= want_d; empty_q <= empty_d;
      lvl_q <= lvl_d; ovf_q <= ovf_d;
      need_apply_q <= need_apply_d; need_pop_q <= need_pop_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) acc_q <= '0;
    else         acc_q <= acc_d;
  end

  always_ff @(posedge clk_i) begin
    opnd_q <= opnd_d;
  end

  // Push the current level.
  always_ff @(posedge clk_i) begin
    if (push) begin
      stk_acc_q[push_idx]   <= acc_q;
      stk_op_q[push_idx]    <= pend_q;
      stk_empty_q[push_idx] <= empty_q;
    end
  end

  // Restoring divider, one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply_start) begin
      dvd_q <= acc_q; rem_q <= '0; quo_q <= '0; cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_q << 1;
      cnt_q <= cnt_q + CntWidth'(1);
      if (!trial[W]) begin
        rem_q <= trial[W-1:0]; quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[W-1:0]; quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> lvl_q != '0)
    else $error("pop with no open level");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LevelWidth'(NestDepth))
    else $error("nest level beyond stack depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply_done |=> !want_q && !empty_q)
    else $error("apply left level in operand state");
endmodule

// File: hw/rtl/tee_ctrl.sv
// Controller: sequences token handling, division, level pops and output.
module tee_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_last_i,
  output logic              out_valid,
  input  logic              out_stall,
  output tee_pkg::tee_cmd_t cmd_o,
  input  tee_pkg::tee_sts_t sts_i
);
  import tee_pkg::*;

  state_e state_q, state_d;
  logic   last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; last_q <= 1'b0;
    end else begin
      state_q <= state_d; last_q <= last_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q; last_d = last_q; cmd_o = '0;
    in_stall = 1'b1; out_valid = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd_o.token_load = 1'b1; last_d = in_last_i; state_d = StApply;
        end
      end
      StApply: begin
        if (sts_i.need_apply) begin
          cmd_o.apply_start = 1'b1;
          state_d = sts_i.is_div ? StDivide : StFlush;
          if (!sts_i.is_div) cmd_o.apply_done = 1'b1;
        end else if (sts_i.need_pop) begin
          cmd_o.pop = 1'b1;
        end else begin
          state_d = StFlush;
        end
      end
      StDivide: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = StPop;
      end
      StPop: begin
        cmd_o.apply_done = 1'b1; state_d = StFlush;
      end
      StFlush: begin
        if (!last_q) state_d = StIdle;
        else if (sts_i.level_open) begin
          cmd_o.pop = 1'b1; state_d = StApply;
        end else state_d = StOut;
      end
      StOut: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd_o.clear = 1'b1; state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall)
    else $error("input taken while result waits");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivide) |-> in_stall && !out_valid)
    else $error("handshake open during divide");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");
endmodule

// File: hw/rtl/token_expression_evaluator.sv
// Top level of the token expression evaluator.
// One token is taken per transfer and evaluated strictly left to right.
// Each token passes the load, apply and flush states, and a close first pops
// its level; a division or modulo by a nonzero divisor runs the
// one-bit-per-cycle restoring divider (32 steps and one write-back). The
// final token pops and applies each open level in turn, then presents
// the result, which is held until transferred. No input is taken while
// an item is in work.
module token_expression_evaluator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     cmd_i,
  input  logic [tee_pkg::ValueWidth-1:0] token_value_i,
  input  logic [3:0]                     op_code_i,
  input  logic                           last_i,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tee_pkg::ValueWidth-1:0] result_o,
  output logic                           nest_overflow_o
);
  import tee_pkg::*;

  tee_cmd_t cmd;
  tee_sts_t sts;

  tee_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_last_i(last_i),
    .out_valid, .out_stall, .cmd_o(cmd), .sts_i(sts)
  );

  tee_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .tok_cmd_i(cmd_i),
    .tok_value_i(token_value_i), .tok_op_i(op_code_i),
    .result_o, .overflow_o(nest_overflow_o)
  );
endmodule
